// ===== rtl/core/bth_pkg.sv =====
// Package for the bounded top-K heap: codes, state type, widths and the key compare.
// Used by bth_store, bounded_topk_heap and bth_check. No dependencies.
`timescale 1ns / 1ps

package bth_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_W_MAX    = 64;
  localparam int LIMIT_W      = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DRAIN  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT        = 2'd0,
    CFG_KEEP_LARGEST = 2'd1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_POP_RD,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_CH,
    ST_DN_CMP,
    ST_DN_END,
    ST_OUT_EMPTY,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic we;
    logic rea;
    logic reb;
  } bth_mem_ctl_t;

  // true when a ranks strictly above b
  function automatic logic key_better(input logic largest,
                                      input logic [KEY_W_MAX-1:0] a,
                                      input logic [KEY_W_MAX-1:0] b);
    return largest ? (a > b) : (a < b);
  endfunction

endpackage

// ===== rtl/core/bth_store.sv =====
// Heap entry storage: key and tag arrays, one write port and two registered read ports.
// Depends on bth_pkg.
`timescale 1ns / 1ps

module bth_store import bth_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KB       = KEY_BITS_DEF
) (
  input  logic                        clk,
  input  bth_mem_ctl_t                ctl,
  input  logic [$clog2(CAPACITY)-1:0] waddr,
  input  logic [KB-1:0]               wkey,
  input  logic [31:0]                 wtag,
  input  logic [$clog2(CAPACITY)-1:0] raddr_a,
  input  logic [$clog2(CAPACITY)-1:0] raddr_b,
  output logic [KB-1:0]               a_key,
  output logic [31:0]                 a_tag,
  output logic [KB-1:0]               b_key,
  output logic [31:0]                 b_tag
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int DEPTH = 1 << AW;

  logic [KB-1:0] keys [DEPTH];
  logic [31:0]   tags [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      keys[waddr] <= wkey;
      tags[waddr] <= wtag;
    end
    if (ctl.rea) begin
      a_key <= keys[raddr_a];
      a_tag <= tags[raddr_a];
    end
    if (ctl.reb) begin
      b_key <= keys[raddr_b];
      b_tag <= tags[raddr_b];
    end
  end

endmodule

// ===== rtl/core/bounded_topk_heap.sv =====
// Bounded top-K binary heap: sequencer, shared key comparator and output register.
// Depends on bth_pkg and bth_store.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  in       to block   in_valid / in_stall       mode, key, tag
//  out      from block out_valid / out_stall     status, out_key, out_tag, last, count
//  cfg      to block   cfg_we                    cfg_index, cfg_data
//
//  Insert with room: the entry climbs from the new last slot past each parent it ranks above.
//  At the limit, an insert is dropped unless it ranks above the root, which it then replaces
//  before sifting down. Pop: the last entry sifts down from the root and the removed root is
//  parked at the old last slot and sent. Empty pop or drain sends an empty status result.
//  Drain of n: n-1 root removals, then every entry is read from slot 1 up and sent. The store
//  reads are registered. Reset clears fill, sequencer, config and out_valid, not key/tag data.
//  A stalled output holds its transfer; the next item is taken once the sequencer is idle.

module bounded_topk_heap import bth_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [31:0]           key,
  input  logic [31:0]           tag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  status,
  output logic [31:0]           out_key,
  output logic [31:0]           out_tag,
  output logic                  last,
  output logic [6:0]            count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(2 * CAPACITY + 2);
  localparam int KB = (KEY_BITS < 32) ? KEY_BITS : 32;

  state_t state, state_next;
  mode_t  op, op_next;

  logic [LIMIT_W-1:0] limit;
  logic               keep_largest;
  logic [LIMIT_W-1:0] lim_eff, fill_w;

  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] n_reg, n_next;
  logic [FW-1:0] cnt, cnt_next;
  logic [FW-1:0] idx, idx_next;
  logic [SW-1:0] pos, pos_next;
  logic [SW-1:0] cpos, cpos_next;
  logic [SW-1:0] child, child1, fill_s;

  logic [KB-1:0] k_reg, k_next, c_key, c_key_next, r_key, r_key_next;
  logic [31:0]   t_reg, t_next, c_tag, c_tag_next, r_tag, r_tag_next;

  bth_mem_ctl_t  mem_ctl;
  logic [SW-1:0] wr_slot, ra_slot, rb_slot;
  logic [SW-1:0] wr_off, ra_off, rb_off;
  logic [KB-1:0] wkey, a_key, b_key;
  logic [31:0]   wtag, a_tag, b_tag;

  logic [KB-1:0] cmp_a, cmp_b;
  logic          cmp_better, sel_b, out_free;

  logic          o_load, o_status, o_last;
  logic [31:0]   o_key, o_tag;
  logic [6:0]    o_count;

  assign lim_eff  = (limit > LIMIT_W'(CAPACITY)) ? LIMIT_W'(CAPACITY) : limit;
  assign fill_w   = LIMIT_W'(fill);
  assign fill_s   = SW'(fill);
  assign child    = pos << 1;
  assign child1   = child + SW'(1);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  assign wr_off = wr_slot - SW'(1);
  assign ra_off = ra_slot - SW'(1);
  assign rb_off = rb_slot - SW'(1);

  assign cmp_a      = (state == ST_UP_CMP || state == ST_DN_CH) ? a_key : k_reg;
  assign cmp_b      = (state == ST_DN_CMP) ? c_key :
                      (state == ST_UP_CMP) ? k_reg :
                      (state == ST_DN_CH)  ? b_key : a_key;
  assign cmp_better = key_better(keep_largest, KEY_W_MAX'(cmp_a), KEY_W_MAX'(cmp_b));
  assign sel_b      = (child < fill_s) && cmp_better;

  bth_store #(
    .CAPACITY (CAPACITY),
    .KB       (KB)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (wr_off[AW-1:0]),
    .wkey    (wkey),
    .wtag    (wtag),
    .raddr_a (ra_off[AW-1:0]),
    .raddr_b (rb_off[AW-1:0]),
    .a_key   (a_key),
    .a_tag   (a_tag),
    .b_key   (b_key),
    .b_tag   (b_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= LIMIT_RESET;
      keep_largest <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT:        limit        <= cfg_data;
        CFG_KEEP_LARGEST: keep_largest <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= MODE_INSERT;
      fill  <= '0;
      n_reg <= '0;
      cnt   <= '0;
      idx   <= '0;
      pos   <= '0;
      cpos  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      fill  <= fill_next;
      n_reg <= n_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      pos   <= pos_next;
      cpos  <= cpos_next;
    end
  end

  always_ff @(posedge clk) begin
    k_reg <= k_next;
    t_reg <= t_next;
    c_key <= c_key_next;
    c_tag <= c_tag_next;
    r_key <= r_key_next;
    r_tag <= r_tag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      status  <= o_status;
      out_key <= o_key;
      out_tag <= o_tag;
      last    <= o_last;
      count   <= o_count;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    fill_next  = fill;
    n_next     = n_reg;
    cnt_next   = cnt;
    idx_next   = idx;
    pos_next   = pos;
    cpos_next  = cpos;
    k_next     = k_reg;
    t_next     = t_reg;
    c_key_next = c_key;
    c_tag_next = c_tag;
    r_key_next = r_key;
    r_tag_next = r_tag;
    mem_ctl    = '0;
    wr_slot    = pos;
    ra_slot    = pos;
    rb_slot    = pos;
    wkey       = k_reg;
    wtag       = t_reg;
    o_load     = 1'b0;
    o_status   = 1'b0;
    o_key      = '0;
    o_tag      = '0;
    o_last     = 1'b0;
    o_count    = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          k_next = key[KB-1:0];
          t_next = tag;
          case (mode)
            MODE_INSERT: begin
              op_next = MODE_INSERT;
              if (fill_w < lim_eff) begin
                fill_next  = fill + FW'(1);
                pos_next   = fill_s + SW'(1);
                state_next = ST_UP_RD;
              end else if (fill != '0) begin
                state_next = ST_ROOT_RD;
              end
            end
            MODE_POP: begin
              op_next = MODE_POP;
              if (fill == '0) begin
                state_next = ST_OUT_EMPTY;
              end else begin
                state_next = ST_POP_RD;
              end
            end
            MODE_DRAIN: begin
              op_next = MODE_DRAIN;
              if (fill == '0) begin
                state_next = ST_OUT_EMPTY;
              end else begin
                cnt_next = fill;
                if (fill > FW'(1)) begin
                  state_next = ST_POP_RD;
                end else begin
                  fill_next  = '0;
                  idx_next   = FW'(1);
                  state_next = ST_EM_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_UP_RD: begin
        if (pos == SW'(1)) begin
          mem_ctl.we = 1'b1;
          state_next = ST_IDLE;
        end else begin
          mem_ctl.rea = 1'b1;
          ra_slot     = pos >> 1;
          state_next  = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        mem_ctl.we = 1'b1;
        if (!cmp_better) begin
          state_next = ST_IDLE;
        end else begin
          wkey       = a_key;
          wtag       = a_tag;
          pos_next   = pos >> 1;
          state_next = ST_UP_RD;
        end
      end

      ST_ROOT_RD: begin
        mem_ctl.rea = 1'b1;
        ra_slot     = SW'(1);
        state_next  = ST_ROOT_CMP;
      end

      ST_ROOT_CMP: begin
        if (cmp_better) begin
          pos_next   = SW'(1);
          state_next = ST_DN_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_POP_RD: begin
        mem_ctl.rea = 1'b1;
        mem_ctl.reb = 1'b1;
        ra_slot     = SW'(1);
        rb_slot     = fill_s;
        n_next      = fill;
        fill_next   = fill - FW'(1);
        state_next  = ST_POP_LD;
      end

      ST_POP_LD: begin
        r_key_next = a_key;
        r_tag_next = a_tag;
        k_next     = b_key;
        t_next     = b_tag;
        pos_next   = SW'(1);
        state_next = ST_DN_RD;
      end

      ST_DN_RD: begin
        if (child > fill_s) begin
          mem_ctl.we = 1'b1;
          state_next = ST_DN_END;
        end else begin
          mem_ctl.rea = 1'b1;
          mem_ctl.reb = 1'b1;
          ra_slot     = child;
          rb_slot     = child1;
          state_next  = ST_DN_CH;
        end
      end

      ST_DN_CH: begin
        c_key_next = sel_b ? b_key : a_key;
        c_tag_next = sel_b ? b_tag : a_tag;
        cpos_next  = sel_b ? child1 : child;
        state_next = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        mem_ctl.we = 1'b1;
        if (!cmp_better) begin
          state_next = ST_DN_END;
        end else begin
          wkey       = c_key;
          wtag       = c_tag;
          pos_next   = cpos;
          state_next = ST_DN_RD;
        end
      end

      ST_DN_END: begin
        // park the removed root at the old last slot
        wr_slot = SW'(n_reg);
        wkey    = r_key;
        wtag    = r_tag;
        case (op)
          MODE_POP: begin
            mem_ctl.we = 1'b1;
            if (out_free) begin
              o_load     = 1'b1;
              o_key      = 32'(r_key);
              o_tag      = r_tag;
              o_last     = 1'b1;
              state_next = ST_IDLE;
            end
          end
          MODE_DRAIN: begin
            mem_ctl.we = 1'b1;
            if (fill > FW'(1)) begin
              state_next = ST_POP_RD;
            end else begin
              fill_next  = '0;
              idx_next   = FW'(1);
              state_next = ST_EM_RD;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end

      ST_OUT_EMPTY: begin
        if (out_free) begin
          o_load     = 1'b1;
          o_status   = 1'b1;
          o_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_EM_RD: begin
        mem_ctl.rea = 1'b1;
        ra_slot     = SW'(idx);
        state_next  = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        if (out_free) begin
          o_load  = 1'b1;
          o_key   = 32'(a_key);
          o_tag   = a_tag;
          o_last  = (idx == cnt);
          o_count = 7'(cnt);
          if (idx == cnt) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + FW'(1);
            state_next = ST_EM_RD;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/bth_check.sv =====
// Port-level checks for bounded_topk_heap and the bind that attaches them.
// Depends on bth_pkg and bounded_topk_heap.
`timescale 1ns / 1ps

module bth_check import bth_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [31:0] out_key,
  input logic [31:0] out_tag,
  input logic        last,
  input logic [6:0]  count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_tag) &&
      $stable(status) && $stable(last) && $stable(count))
    else $error("stalled output transfer changed");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_POP) |=> in_stall)
    else $error("pop accepted without going busy");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && (out_key == 32'd0) && (out_tag == 32'd0) &&
      (count == 7'd0))
    else $error("empty status result malformed");

  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && !last |-> (count != 7'd0))
    else $error("drain result without count");

endmodule

bind bounded_topk_heap bth_check u_bth_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_key   (out_key),
  .out_tag   (out_tag),
  .last      (last),
  .count     (count)
);
